FILE: design/fbr_pkg.sv
// Shared types, constants and the CRC byte update for the framed byte receiver.
`timescale 1ns / 1ps

package fbr_pkg;

	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int HDR_LEN         = 7;
	localparam int CRC_LEN         = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] START_RESET   = 8'd170;
	localparam logic [7:0] VERSION_RESET = 8'd2;
	localparam logic [7:0] REQUEST_RESET = 8'd1;

	// configuration register indexes
	localparam logic [1:0] REG_START_BYTE   = 2'd0;
	localparam logic [1:0] REG_EXP_VERSION  = 2'd1;
	localparam logic [1:0] REG_REQUEST_TYPE = 2'd2;

	// outcome of a byte that completes a frame
	typedef enum logic [1:0] {
		V_NONE  = 2'd0,
		V_ERR   = 2'd1,
		V_EMPTY = 2'd2,
		V_DATA  = 2'd3
	} verdict_t;

	typedef struct packed {
		verdict_t   kind;
		logic [7:0] opcode;
		logic [7:0] sequence_res;
		logic [7:0] length;
	} finish_t;

	typedef struct packed {
		logic       frame_status;
		logic [7:0] opcode;
		logic [7:0] sequence_res;
		logic [5:0] payload_length;
		logic       has_byte;
		logic [4:0] byte_index;
		logic [7:0] payload_byte;
		logic       last;
	} result_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/fbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/fbr_parser.sv
// Frame parser: start hunt, header capture, running CRC and end-of-frame verdict.
`timescale 1ns / 1ps

module fbr_parser #(
	parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEF,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic [7:0]          ram_wdata,
	output fbr_pkg::finish_t    fin
);

	localparam int CW = $clog2(fbr_pkg::HDR_LEN + MAX_PAYLOAD + fbr_pkg::CRC_LEN + 2);
	localparam logic [CW-1:0] HDR_C   = CW'(fbr_pkg::HDR_LEN);
	localparam logic [CW-1:0] CRC_C   = CW'(fbr_pkg::CRC_LEN);
	localparam logic [CW-1:0] FIXED_C = CW'(fbr_pkg::HDR_LEN + fbr_pkg::CRC_LEN);
	localparam logic [7:0]    MAX_C   = 8'(MAX_PAYLOAD);

	logic [7:0]    start_q, version_q, reqtype_q;
	logic          in_frame_q, in_frame_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc, pay_off;
	logic [CW-1:0] et_q, et_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    crcl_q;
	logic [7:0]    hdr_q [6];
	logic          hdr_we, crcl_we, crc_ok;
	logic [2:0]    hdr_sel;

	assign cnt_inc   = cnt_q + CW'(1);
	assign pay_off   = cnt_q - HDR_C;
	assign hdr_sel   = 3'(cnt_q - CW'(1));
	assign ram_waddr = pay_off[AW-1:0];
	assign ram_wdata = rx_byte;
	assign crc_ok    = ({rx_byte, crcl_q} == crc_q);

	always_comb begin
		in_frame_d       = in_frame_q;
		cnt_d            = cnt_q;
		et_d             = et_q;
		crc_d            = crc_q;
		hdr_we           = 1'b0;
		crcl_we          = 1'b0;
		ram_we           = 1'b0;
		fin.kind         = fbr_pkg::V_NONE;
		fin.opcode       = hdr_q[2];
		fin.sequence_res = hdr_q[3];
		fin.length       = hdr_q[5];
		if (accept) begin
			if (rx_byte == start_q) begin
				// restart on any start byte, even mid-frame
				in_frame_d = 1'b1;
				cnt_d      = CW'(1);
				et_d       = '0;
				crc_d      = fbr_pkg::CRC_INIT;
			end else if (in_frame_q) begin
				if (cnt_q >= CW'(1) && cnt_q < HDR_C) begin
					hdr_we = 1'b1;
					crc_d  = fbr_pkg::crc16_feed(crc_q, rx_byte);
				end else if (et_q != '0 && cnt_q + CRC_C < et_q) begin
					ram_we = 1'b1;
					crc_d  = fbr_pkg::crc16_feed(crc_q, rx_byte);
				end else if (et_q != '0 && cnt_q + CRC_C == et_q) begin
					crcl_we = 1'b1;
				end
				cnt_d = cnt_inc;
				if (cnt_inc == HDR_C) begin
					// length byte just arrived
					if (rx_byte > MAX_C) begin
						in_frame_d = 1'b0;
						cnt_d      = '0;
						et_d       = '0;
					end else begin
						et_d = FIXED_C + CW'(rx_byte);
					end
				end
				if (et_q != '0 && cnt_inc == et_q) begin
					in_frame_d = 1'b0;
					cnt_d      = '0;
					et_d       = '0;
					if (!crc_ok) begin
						fin.kind = fbr_pkg::V_NONE;
					end else if (hdr_q[0] != version_q) begin
						fin.kind = fbr_pkg::V_ERR;
					end else if (hdr_q[1] != reqtype_q) begin
						fin.kind = fbr_pkg::V_NONE;
					end else if (hdr_q[5] == 8'd0) begin
						fin.kind = fbr_pkg::V_EMPTY;
					end else begin
						fin.kind = fbr_pkg::V_DATA;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= fbr_pkg::START_RESET;
			version_q  <= fbr_pkg::VERSION_RESET;
			reqtype_q  <= fbr_pkg::REQUEST_RESET;
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			et_q       <= '0;
			crc_q      <= fbr_pkg::CRC_INIT;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					fbr_pkg::REG_START_BYTE:   start_q   <= cfg_wdata;
					fbr_pkg::REG_EXP_VERSION:  version_q <= cfg_wdata;
					fbr_pkg::REG_REQUEST_TYPE: reqtype_q <= cfg_wdata;
					default: ;
				endcase
			end
			in_frame_q <= in_frame_d;
			cnt_q      <= cnt_d;
			et_q       <= et_d;
			crc_q      <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[hdr_sel] <= rx_byte;
		end
		if (crcl_we) begin
			crcl_q <= rx_byte;
		end
	end

	a_total_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		et_q != '0 |-> in_frame_q)
		else $error("frame total known outside a frame");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		et_q != '0 |-> cnt_q < et_q)
		else $error("byte count ran past the frame total");

	a_idle_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> cnt_q == '0 && et_q == '0)
		else $error("count left over outside a frame");

endmodule

FILE: design/framed_byte_receiver_crc16.sv
// Top level: parser, payload RAM and the result replay with its output register.
`timescale 1ns / 1ps

// Framed byte receiver with CRC-16/CCITT-FALSE check.
// Input channel (in_valid/in_stall, rx_byte) takes one received serial byte per
// transfer. The block hunts for start_byte, captures the 7-byte header, writes
// the payload into a RAM of MAX_PAYLOAD bytes and checks the trailing
// little-endian CRC. Output channel (out_valid/out_stall) carries one result per
// transfer: a version error, an empty request, or one result per payload byte.
// A byte that does not end a frame is absorbed by the parser, and a new byte
// may follow it while in_stall stays low. The byte that ends a frame loads an
// error or empty result into the output register at once; a good request with
// payload starts a replay from the RAM: each result is read from the RAM, then
// loaded into the output register, and the next read waits until it is taken;
// input is stalled until the final result is loaded.
// A stalled output holds its result; input stays stalled while a replay is
// in progress or while a held result cannot drain. A byte is taken in the
// cycle the last result of a frame leaves the output register, since that
// register parts the sides.
// Reset clears the frame state and the output valid flag, seeds the CRC and
// loads the register defaults; the RAM is not cleared and needs no clearing pass.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) takes effect on the next byte.
module framed_byte_receiver_crc16 #(
	parameter int MAX_PAYLOAD = fbr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       frame_status,
	output logic [7:0] opcode,
	output logic [7:0] sequence_res,
	output logic [5:0] payload_length,
	output logic       has_byte,
	output logic [4:0] byte_index,
	output logic [7:0] payload_byte,
	output logic       last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic              out_valid_q, out_valid_d;
	fbr_pkg::result_t  out_q, res_d;
	logic              load;
	logic              in_acc, out_take;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic              rd_last;
	fbr_pkg::finish_t  fin;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign rd_last  = (8'(idx_q) + 8'd1) == fin.length;

	fbr_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (in_acc),
		.rx_byte   (rx_byte),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.fin       (fin)
	);

	fbr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		state_d                = state_q;
		idx_d                  = idx_q;
		rd_en                  = 1'b0;
		rd_addr                = idx_q;
		load                   = 1'b0;
		res_d.frame_status     = 1'b0;
		res_d.opcode           = fin.opcode;
		res_d.sequence_res     = fin.sequence_res;
		res_d.payload_length   = fin.length[5:0];
		res_d.has_byte         = 1'b0;
		res_d.byte_index       = '0;
		res_d.payload_byte     = '0;
		res_d.last             = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (fin.kind)
						fbr_pkg::V_ERR: begin
							load               = 1'b1;
							res_d.frame_status = 1'b1;
						end
						fbr_pkg::V_EMPTY: begin
							load = 1'b1;
						end
						fbr_pkg::V_DATA: begin
							rd_en   = 1'b1;
							rd_addr = '0;
							idx_d   = '0;
							state_d = S_READ;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				// read data is back; output register is known empty here
				load               = 1'b1;
				res_d.has_byte     = 1'b1;
				res_d.byte_index   = 5'(idx_q);
				res_d.payload_byte = rd_data;
				res_d.last         = rd_last;
				state_d            = rd_last ? S_IDLE : S_HOLD;
			end
			S_HOLD: begin
				if (out_take) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(1);
					idx_d   = idx_q + AW'(1);
					state_d = S_READ;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		out_valid_d = load ? 1'b1 : (out_take ? 1'b0 : out_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_status   = out_q.frame_status;
	assign opcode         = out_q.opcode;
	assign sequence_res   = out_q.sequence_res;
	assign payload_length = out_q.payload_length;
	assign has_byte       = out_q.has_byte;
	assign byte_index     = out_q.byte_index;
	assign payload_byte   = out_q.payload_byte;
	assign last           = out_q.last;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !out_valid_q)
		else $error("replay read returned while output register was full");

	a_hold_after_partial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> state_q == S_HOLD)
		else $error("non-final result without replay in progress");

	a_replay_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> 8'(idx_q) < fin.length)
		else $error("replay index beyond payload length");

	a_no_parse_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !ram_we)
		else $error("payload write during replay");

endmodule

FILE: tb/sv/framed_byte_receiver_crc16_test.sv
// Self-checking testbench for the framed byte receiver with CRC-16 check.
`timescale 1ns / 1ps

module framed_byte_receiver_crc16_test;

	localparam int MAX_LEN = fbr_pkg::MAX_PAYLOAD_DEF;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		FR_CLEAN   = 2'd0,
		FR_BAD_CRC = 2'd1,
		FR_CUT     = 2'd2,
		FR_RESTART = 2'd3
	} frame_fault_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       frame_status;
	logic [7:0] opcode;
	logic [7:0] sequence_res;
	logic [5:0] payload_length;
	logic       has_byte;
	logic [4:0] byte_index;
	logic [7:0] payload_byte;
	logic       last;

	// register copies and parser state of the predictor
	logic [7:0]  cfg_start = fbr_pkg::START_RESET;
	logic [7:0]  cfg_version = fbr_pkg::VERSION_RESET;
	logic [7:0]  cfg_request = fbr_pkg::REQUEST_RESET;
	bit          rx_in_frame = 1'b0;
	int          rx_count = 0;
	int          rx_total = 0;
	logic [7:0]  hdr_bytes [6];
	logic [7:0]  pay_bytes [MAX_LEN];
	logic [7:0]  crc_lo_byte;
	logic [15:0] crc_run = fbr_pkg::CRC_INIT;

	logic [7:0]        tx_bytes [$];
	fbr_pkg::result_t  pending_results [$];
	int         bytes_queued = 0;
	int         bytes_taken = 0;
	int         errors = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	int         hold_left = 0;
	bit         hold_req = 1'b0;
	bit         hold_seen = 1'b0;
	bit         calm = 1'b0;

	framed_byte_receiver_crc16 dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.opcode         (opcode),
		.sequence_res   (sequence_res),
		.payload_length (payload_length),
		.has_byte       (has_byte),
		.byte_index     (byte_index),
		.payload_byte   (payload_byte),
		.last           (last)
	);

	always #2 clk = ~clk;

	function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ data[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ fbr_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// random byte that is neither the given value nor the start byte
	function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		while (v == avoid || v == cfg_start) begin
			v = 8'($urandom_range(0, 255));
		end
		return v;
	endfunction

	// advance the parser by one accepted byte and queue the results it releases
	task automatic track_rx_byte(input logic [7:0] b);
		int               pos;
		int               len;
		fbr_pkg::result_t r;
		if (b == cfg_start) begin
			rx_in_frame = 1'b1;
			rx_count = 1;
			rx_total = 0;
			crc_run = fbr_pkg::CRC_INIT;
			return;
		end
		if (!rx_in_frame) begin
			return;
		end
		pos = rx_count;
		if (pos >= 1 && pos < fbr_pkg::HDR_LEN) begin
			hdr_bytes[pos - 1] = b;
			crc_run = crc_next(crc_run, b);
		end else if (rx_total != 0 && pos < rx_total - fbr_pkg::CRC_LEN) begin
			if (pos - fbr_pkg::HDR_LEN < MAX_LEN) begin
				pay_bytes[pos - fbr_pkg::HDR_LEN] = b;
			end
			crc_run = crc_next(crc_run, b);
		end else if (rx_total != 0 && pos == rx_total - fbr_pkg::CRC_LEN) begin
			crc_lo_byte = b;
		end
		rx_count = pos + 1;
		if (rx_count == fbr_pkg::HDR_LEN) begin
			if (hdr_bytes[5] > MAX_LEN) begin
				rx_in_frame = 1'b0;
				rx_count = 0;
				rx_total = 0;
				return;
			end
			rx_total = fbr_pkg::HDR_LEN + hdr_bytes[5] + fbr_pkg::CRC_LEN;
		end
		if (rx_total == 0 || rx_count < rx_total) begin
			return;
		end
		rx_in_frame = 1'b0;
		rx_count = 0;
		rx_total = 0;
		if ({b, crc_lo_byte} != crc_run) begin
			return;
		end
		r = '0;
		r.opcode = hdr_bytes[2];
		r.sequence_res = hdr_bytes[3];
		r.payload_length = hdr_bytes[5][5:0];
		r.last = 1'b1;
		if (hdr_bytes[0] != cfg_version) begin
			r.frame_status = 1'b1;
			pending_results.push_back(r);
		end else if (hdr_bytes[1] != cfg_request) begin
			return;
		end else if (hdr_bytes[5] == 8'd0) begin
			pending_results.push_back(r);
		end else begin
			len = hdr_bytes[5];
			for (int i = 0; i < len; i++) begin
				r.has_byte = 1'b1;
				r.byte_index = i[4:0];
				r.payload_byte = pay_bytes[i];
				r.last = (i == len - 1);
				pending_results.push_back(r);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endtask

	// build one frame; a length above the limit sends the header alone
	task automatic queue_frame(input logic [7:0] ver, input logic [7:0] kind_byte,
			input int len, input frame_fault_t fault);
		logic [7:0]  frm [$];
		logic [7:0]  dummy;
		logic [15:0] crc;
		int          cut;
		frm.push_back(cfg_start);
		frm.push_back(ver);
		frm.push_back(kind_byte);
		frm.push_back(pick_byte(cfg_start));
		frm.push_back(pick_byte(cfg_start));
		frm.push_back(pick_byte(cfg_start));
		frm.push_back(len[7:0]);
		if (len <= MAX_LEN) begin
			for (int i = 0; i < len; i++) begin
				frm.push_back(pick_byte(cfg_start));
			end
			crc = fbr_pkg::CRC_INIT;
			for (int j = 1; j < frm.size(); j++) begin
				crc = crc_next(crc, frm[j]);
			end
			if (fault == FR_BAD_CRC) begin
				crc = crc ^ (16'h0001 << $urandom_range(0, 15));
			end
			frm.push_back(crc[7:0]);
			frm.push_back(crc[15:8]);
		end
		if (fault == FR_CUT) begin
			cut = $urandom_range(1, frm.size() - 2);
			while (frm.size() > cut) begin
				dummy = frm.pop_back();
			end
		end else if (fault == FR_RESTART) begin
			frm[$urandom_range(1, frm.size() - 1)] = cfg_start;
		end
		foreach (frm[k]) begin
			queue_byte(frm[k]);
		end
	endtask

	task automatic queue_random(input int target);
		int goal;
		int pick;
		int len;
		goal = bytes_queued + target;
		while (bytes_queued < goal) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_LEN) : $urandom_range(0, 8);
			if (pick < 60) begin
				queue_frame(cfg_version, cfg_request, len, FR_CLEAN);
			end else if (pick < 67) begin
				queue_frame(pick_byte(cfg_version), pick_byte(cfg_start), len, FR_CLEAN);
			end else if (pick < 73) begin
				queue_frame(cfg_version, pick_byte(cfg_request), len, FR_CLEAN);
			end else if (pick < 79) begin
				queue_frame(cfg_version, cfg_request, len, FR_BAD_CRC);
			end else if (pick < 84) begin
				queue_frame(cfg_version, cfg_request, $urandom_range(MAX_LEN + 1, 255), FR_CLEAN);
			end else if (pick < 89) begin
				queue_frame(cfg_version, cfg_request, len, FR_CUT);
			end else if (pick < 94) begin
				queue_frame(cfg_version, cfg_request, len, FR_RESTART);
			end else begin
				repeat ($urandom_range(1, 4)) queue_byte(pick_byte(cfg_start));
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			fbr_pkg::REG_START_BYTE: begin
				cfg_start = val;
			end
			fbr_pkg::REG_EXP_VERSION: begin
				cfg_version = val;
			end
			fbr_pkg::REG_REQUEST_TYPE: begin
				cfg_request = val;
			end
			default: begin
			end
		endcase
	endtask

	// wait until every byte is taken and every result is out
	task automatic drain();
		while (bytes_taken != bytes_queued) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// byte sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_rx_byte(rx_byte);
				bytes_taken++;
			end
			if (in_valid && in_stall) begin
				// hold the offered byte
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (tx_bytes.size() != 0 && !calm && $urandom_range(0, 99) < gap_pct) begin
				send_gap = $urandom_range(0, 7);
				in_valid <= 1'b0;
			end else if (tx_bytes.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver and checker
	always @(posedge clk or negedge arst_n) begin
		fbr_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result expected none actual opcode %0h index %0h byte %0h",
						$time, opcode, byte_index, payload_byte);
				end else begin
					want = pending_results.pop_front();
					check_field("frame_status", 8'(want.frame_status), 8'(frame_status));
					check_field("opcode", want.opcode, opcode);
					check_field("sequence_res", want.sequence_res, sequence_res);
					check_field("payload_length", 8'(want.payload_length),
						8'(payload_length));
					check_field("has_byte", 8'(want.has_byte), 8'(has_byte));
					check_field("byte_index", 8'(want.byte_index), 8'(byte_index));
					check_field("payload_byte", want.payload_byte, payload_byte);
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [7:0] s;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 15;
		stall_pct = 15;
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_frame(cfg_version, cfg_request, 0, FR_CLEAN);
		queue_frame(pick_byte(cfg_version), pick_byte(cfg_request), 2, FR_CLEAN);
		queue_frame(cfg_version, pick_byte(cfg_request), 1, FR_CLEAN);
		queue_frame(cfg_version, cfg_request, 3, FR_BAD_CRC);
		queue_frame(cfg_version, cfg_request, MAX_LEN + 1, FR_CLEAN);
		queue_frame(cfg_version, cfg_request, 4, FR_RESTART);
		queue_frame(cfg_version, cfg_request, MAX_LEN, FR_CLEAN);
		queue_frame(cfg_version, cfg_request, 2, FR_CUT);
		queue_frame(cfg_version, cfg_request, 1, FR_CLEAN);
		drain();
		queue_random(30);
		drain();

		write_reg(fbr_pkg::REG_START_BYTE, 8'h00);
		write_reg(fbr_pkg::REG_EXP_VERSION, 8'hFF);
		write_reg(fbr_pkg::REG_REQUEST_TYPE, 8'h80);
		write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
		gap_pct = 0;
		stall_pct = 0;
		queue_random(15);
		drain();

		write_reg(fbr_pkg::REG_START_BYTE, 8'hFF);
		write_reg(fbr_pkg::REG_EXP_VERSION, 8'h00);
		write_reg(fbr_pkg::REG_REQUEST_TYPE, 8'h00);
		// long receiver hold-off while full frames keep arriving
		stall_pct = 20;
		hold_req = 1'b1;
		repeat (2) queue_frame(cfg_version, cfg_request, MAX_LEN, FR_CLEAN);
		drain();
		gap_pct = 25;
		stall_pct = 25;
		queue_random(15);
		drain();

		s = 8'($urandom_range(0, 255));
		write_reg(fbr_pkg::REG_START_BYTE, s);
		write_reg(fbr_pkg::REG_EXP_VERSION, pick_byte(s));
		write_reg(fbr_pkg::REG_REQUEST_TYPE, pick_byte(cfg_version));
		write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
		gap_pct = 10;
		stall_pct = 30;
		queue_random(15);
		drain();

		write_reg(fbr_pkg::REG_START_BYTE, fbr_pkg::START_RESET);
		write_reg(fbr_pkg::REG_EXP_VERSION, fbr_pkg::VERSION_RESET);
		write_reg(fbr_pkg::REG_REQUEST_TYPE, fbr_pkg::REQUEST_RESET);
		calm = 1'b1;
		queue_random(15);
		drain();

		if (errors == 0) begin
			$display("** framed_byte_receiver_crc16: PASSED **");
		end else begin
			$display("** framed_byte_receiver_crc16: FAILED **");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("** framed_byte_receiver_crc16: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
design/fbr_pkg.sv
design/fbr_ram.sv
design/fbr_parser.sv
design/framed_byte_receiver_crc16.sv
tb/sv/framed_byte_receiver_crc16_test.sv
